FILE: src/sqspir_pkg.sv
package sqspir_pkg;

  localparam int COORD_W = 17;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam logic [1:0] LEG_TOP    = 2'd0;
  localparam logic [1:0] LEG_LEFT   = 2'd1;
  localparam logic [1:0] LEG_BOTTOM = 2'd2;
  localparam logic [1:0] LEG_RIGHT  = 2'd3;

endpackage

FILE: src/square_spiral_index_to_xy.sv
// The result strobe follows the start transfer once the root, the ring offset and, if the
// offset is not zero, the walk along the legs of the ring are done.
// The square root takes one cycle per root bit, then the fix state forms the ring offset and
// the leg state walks the legs of the ring with a single compare and subtract.
// A new item is taken only when the last is through; busy is high while an item is in work.
// Synchronous reset returns the block to idle; the receiver cannot stall a result.
module square_spiral_index_to_xy
  import sqspir_pkg::*;
#(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [INDEX_WIDTH-1:0] step_index,
  output logic                   busy,
  output logic                   done,
  output coord_t                 coord_x,
  output coord_t                 coord_y
);

  localparam int MW = INDEX_WIDTH + 1;
  localparam int RW = (MW + 1) / 2;
  localparam int KW = RW + 3;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_LEG  = 2'd3;

  logic [1:0]    state;
  logic [1:0]    leg;
  logic [RW-1:0] s_val;
  logic [KW-1:0] j_val;
  logic          accept;
  logic [MW-1:0] m_val;
  logic          sq_done;
  logic [RW-1:0] sq_root;
  logic [KW-1:0] sq_rem;

  logic [RW-1:0]      s_next;
  logic [KW-1:0]      k_next;
  logic [KW-1:0]      len;
  logic               fit;
  logic [COORD_W-1:0] s17;
  logic [COORD_W-1:0] s1;
  logic [COORD_W-1:0] j17;
  logic [COORD_W-1:0] x_leg;
  logic [COORD_W-1:0] y_leg;

  assign accept = start && !busy;
  assign m_val  = MW'(step_index) + MW'(1);
  assign busy   = state != ST_IDLE;

  sqspir_isqrt #(.M_WIDTH(MW)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .value (m_val),
    .done  (sq_done),
    .root  (sq_root),
    .rem   (sq_rem)
  );

  always_comb begin
    s_next = (sq_root - RW'(1)) >> 1;
    if (sq_root[0]) begin
      k_next = sq_rem;
    end else begin
      k_next = sq_rem + KW'({sq_root, 1'b0}) - KW'(1);
    end
    if (leg == LEG_TOP) begin
      len = KW'({s_val, 1'b1});
    end else begin
      len = KW'({s_val, 1'b0}) + KW'(2);
    end
    fit = (j_val <= len) || (leg == LEG_RIGHT);
    s17 = COORD_W'(s_val);
    s1  = s17 + COORD_W'(1);
    j17 = COORD_W'(j_val);
    case (leg)
      LEG_TOP: begin
        x_leg = s17 - j17;
        y_leg = s1;
      end
      LEG_LEFT: begin
        x_leg = -s1;
        y_leg = s1 - j17;
      end
      LEG_BOTTOM: begin
        x_leg = j17 - s1;
        y_leg = -s1;
      end
      default: begin
        x_leg = s1;
        y_leg = j17 - s1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sq_done) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          if (k_next == '0) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_LEG;
          end
        end
        ST_LEG: begin
          if (fit) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_FIX: begin
        s_val   <= s_next;
        j_val   <= k_next - KW'(1);
        leg     <= LEG_TOP;
        coord_x <= COORD_W'(s_next);
        coord_y <= COORD_W'(s_next);
      end
      ST_LEG: begin
        if (fit) begin
          coord_x <= x_leg;
          coord_y <= y_leg;
        end else begin
          j_val <= j_val - len;
          leg   <= leg + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/sqspir_isqrt.sv
module sqspir_isqrt
  import sqspir_pkg::*;
#(
  parameter int M_WIDTH = 33
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [M_WIDTH-1:0]            value,
  output logic                          done,
  output logic [(M_WIDTH+1)/2-1:0]      root,
  output logic [(M_WIDTH+1)/2+2:0]      rem
);

  localparam int RW  = (M_WIDTH + 1) / 2;
  localparam int PW  = 2 * RW;
  localparam int RMW = RW + 3;
  localparam int CW  = $clog2(RW + 1);

  logic [PW-1:0]  radicand;
  logic [CW-1:0]  cnt;
  logic           running;
  logic [RMW-1:0] rem_sh;
  logic [RMW-1:0] trial;
  logic           ge;

  always_comb begin
    rem_sh = {rem[RMW-3:0], radicand[PW-1:PW-2]};
    trial  = RMW'({root, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(RW);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      radicand <= PW'(value);
      root     <= '0;
      rem      <= '0;
    end else if (running) begin
      radicand <= {radicand[PW-3:0], 2'b00};
      root     <= {root[RW-2:0], ge};
      rem      <= ge ? (rem_sh - trial) : rem_sh;
    end
  end

endmodule

FILE: src/sqspir_check.sv
module sqspir_check
  import sqspir_pkg::*;
#(
  parameter int INDEX_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic [INDEX_WIDTH-1:0] step_index,
  input logic                   busy,
  input logic                   done,
  input coord_t                 coord_x,
  input coord_t                 coord_y
);

  // A result transfer only appears once the block has gone back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !$isunknown({coord_x, coord_y}))
    else $error("result strobe while busy or with unknown coordinates");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> !$isunknown(step_index) ##1 busy)
    else $error("accepted item was unknown or did not make the block busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // Finishing an item always delivers its result.
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("item finished without a result");

endmodule

bind square_spiral_index_to_xy sqspir_check #(.INDEX_WIDTH(INDEX_WIDTH)) u_check (.*);

FILE: test/testbench.sv
module testbench
  import sqspir_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] index;
    bit          typed;
    coord_t      x;
    coord_t      y;
  } spiral_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] step_index = '0;
  logic        busy;
  logic        done;
  coord_t      coord_x;
  coord_t      coord_y;

  coord_t      want_x_q[$];
  coord_t      want_y_q[$];
  logic [31:0] want_index_q[$];
  int          mismatches = 0;

  coord_t      got_x;
  coord_t      got_y;
  logic [31:0] got_index;

  spiral_row_t spiral_rows[];

  square_spiral_index_to_xy #(
    .INDEX_WIDTH(32)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .step_index(step_index),
    .busy      (busy),
    .done      (done),
    .coord_x   (coord_x),
    .coord_y   (coord_y)
  );

  always #5 clk = ~clk;

  // Closed-form walk of the spiral: find the ring from an exact integer root,
  // then the leg of that ring and the offset along it.
  function automatic void spiral_point(input logic [31:0] n, output coord_t x,
                                       output coord_t y);
    longint ring_m;
    longint root;
    longint trial;
    longint half;
    longint odd;
    longint k;
    longint j;
    longint px;
    longint py;
    ring_m = longint'({32'b0, n}) + 1;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= ring_m) begin
        root = trial;
      end
    end
    half = (root - 1) >>> 1;
    odd = 2 * half + 1;
    k = ring_m - odd * odd;
    if (k == 0) begin
      px = half;
      py = half;
    end else begin
      j = k - 1;
      if (j <= 2 * half + 1) begin
        px = half - j;
        py = half + 1;
      end else begin
        j = j - (2 * half + 1);
        if (j <= 2 * half + 2) begin
          px = -half - 1;
          py = half + 1 - j;
        end else begin
          j = j - (2 * half + 2);
          if (j <= 2 * half + 2) begin
            px = -half - 1 + j;
            py = -half - 1;
          end else begin
            j = j - (2 * half + 2);
            px = half + 1;
            py = -half - 1 + j;
          end
        end
      end
    end
    x = px[COORD_W-1:0];
    y = py[COORD_W-1:0];
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) begin
      return 0;
    end else if (roll < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_index();
    int     mode;
    longint odd;
    longint half;
    longint corner;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      return $urandom;
    end else if (mode < 6) begin
      return $urandom_range(0, 1000);
    end
    // Land on or next to a corner of a random ring, where the legs change.
    odd = longint'($urandom_range(0, 32767)) * 2 + 1;
    half = (odd - 1) / 2;
    corner = odd * odd - 1 + longint'($urandom_range(0, 4)) * (2 * half + 2);
    corner = corner + longint'($urandom_range(0, 4)) - 2;
    return corner[31:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer,
  // leaving start high so that a following item can go back to back.
  task automatic send_index(input logic [31:0] idx, input bit typed, input coord_t tx,
                            input coord_t ty);
    coord_t px;
    coord_t py;
    bit     taken;
    step_index <= idx;
    start <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end
    spiral_point(idx, px, py);
    if (typed) begin
      px = tx;
      py = ty;
    end
    want_x_q.push_back(px);
    want_y_q.push_back(py);
    want_index_q.push_back(idx);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (want_x_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (want_x_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result (%0d,%0d) with no transfer waiting", coord_x, coord_y);
        end
      end else begin
        got_x = want_x_q.pop_front();
        got_y = want_y_q.pop_front();
        got_index = want_index_q.pop_front();
        if (coord_x !== got_x || coord_y !== got_y) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("index %0d: expected (%0d,%0d), got (%0d,%0d)", got_index, got_x, got_y,
                     coord_x, coord_y);
          end
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("square_spiral_index_to_xy test failed");
    $finish;
  end

  initial begin
    spiral_rows = '{
      '{32'd0, 1'b1, 17'sd0, 17'sd0},
      '{32'd1, 1'b1, 17'sd0, 17'sd1},
      '{32'd2, 1'b1, -17'sd1, 17'sd1},
      '{32'd3, 1'b0, 17'sd0, 17'sd0},
      '{32'd4, 1'b0, 17'sd0, 17'sd0},
      '{32'd5, 1'b0, 17'sd0, 17'sd0},
      '{32'd6, 1'b0, 17'sd0, 17'sd0},
      '{32'd7, 1'b0, 17'sd0, 17'sd0},
      '{32'd8, 1'b0, 17'sd0, 17'sd0},
      '{32'd9, 1'b0, 17'sd0, 17'sd0},
      '{32'd10, 1'b0, 17'sd0, 17'sd0},
      '{32'd15, 1'b0, 17'sd0, 17'sd0},
      '{32'd19, 1'b0, 17'sd0, 17'sd0},
      '{32'd23, 1'b0, 17'sd0, 17'sd0},
      '{32'd24, 1'b1, 17'sd2, 17'sd2},
      '{32'd4294836224, 1'b1, 17'sd32767, 17'sd32767},
      '{32'hFFFF_FFFF, 1'b1, -17'sd32768, -17'sd32767},
      '{32'hFFFF_FFFE, 1'b0, 17'sd0, 17'sd0},
      '{32'h8000_0000, 1'b0, 17'sd0, 17'sd0},
      '{32'h7FFF_FFFF, 1'b0, 17'sd0, 17'sd0},
      '{32'hAAAA_AAAA, 1'b0, 17'sd0, 17'sd0},
      '{32'h5555_5555, 1'b0, 17'sd0, 17'sd0},
      '{32'hFFFE_0000, 1'b0, 17'sd0, 17'sd0},
      '{32'h0000_FFFF, 1'b0, 17'sd0, 17'sd0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (spiral_rows[i]) begin
      send_index(spiral_rows[i].index, spiral_rows[i].typed, spiral_rows[i].x,
                 spiral_rows[i].y);
      pause_sender(pick_gap());
    end
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_index(pick_index(), 1'b0, '0, '0);
      if (i == RANDOM_ITEMS / 2) begin
        drain_results();
      end else begin
        pause_sender(pick_gap());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("square_spiral_index_to_xy test passed");
    end else begin
      $display("square_spiral_index_to_xy test failed");
    end
    $finish;
  end

endmodule
